/* src/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  // Default width of the payload length and byte position registers.
  localparam int unsigned LENGTH_BITS_DEFAULT = 64;

  // Header byte fields.
  localparam logic [7:0] HDR_FLAG_MASK   = 8'h80; // FIN / MASK flag
  localparam logic [7:0] HDR_RSV_MASK    = 8'h70; // reserved bits
  localparam logic [7:0] HDR_OPCODE_MASK = 8'h0f;
  localparam logic [7:0] HDR_LEN_MASK    = 8'h7f;
  localparam logic [6:0] LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64  = 7'd127;

  // Field byte counts that complete an extended length or key (3-bit wrap).
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

endpackage

`default_nettype wire

/* src/wsd_byte_if.sv */
// ----------------------------------------------------------------------------
// wsd_byte_if
// Valid/ready channel carrying one received stream byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/wsd_result_if.sv */
// ----------------------------------------------------------------------------
// wsd_result_if
// Valid/ready channel carrying one deframer result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] data_byte;
  logic       frame_fin;
  logic [3:0] frame_opcode;
  logic       was_masked;
  logic       last_of_frame;

  modport source (output valid, output out_kind, output data_byte, output frame_fin,
                  output frame_opcode, output was_masked, output last_of_frame,
                  input ready);
  modport sink   (input valid, input out_kind, input data_byte, input frame_fin,
                  input frame_opcode, input was_masked, input last_of_frame,
                  output ready);
endinterface

`default_nettype wire

/* src/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// A transferred byte is parsed while it sits in the input register, and its
// result loads into the result register when that register can take it.
// One byte per cycle is taken while the result register is not held full.
// Reset (rst, synchronous): back to waiting for the first header byte, both
// pipeline registers empty, all header state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  wsd_byte_if.sink     rx,
  wsd_result_if.source res
);

  // The pipeline has two stages: an input register holding the last
  // transferred byte, and a result register. The parse step sits between
  // them and updates the frame state in the same cycle that it produces a
  // result. Both stages stall together only when the result register is
  // full and the downstream side is not taking it; an empty input register
  // still takes a byte, so one byte is absorbed while a result waits.

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register.
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_data;
  logic       res_fin;
  logic [3:0] res_opcode;
  logic       res_masked;
  logic       res_last;

  // Frame state.
  wsd_pkg::phase_t        phase, phase_next;
  logic [2:0]             field_cnt, field_cnt_next;
  logic                   fin, fin_next;
  logic [3:0]             opcode, opcode_next;
  logic                   masked, masked_next;
  logic [LENGTH_BITS-1:0] plen, plen_next;
  logic [31:0]            key, key_next;
  logic [LENGTH_BITS-1:0] pos, pos_next;

  // Parse step outputs.
  logic                   emit;
  logic [1:0]             emit_kind;
  logic [7:0]             emit_data;
  logic                   emit_masked;
  logic                   emit_last;

  logic                   advance;
  logic                   len_done;
  logic [LENGTH_BITS-1:0] len_val;
  logic [LENGTH_BITS-1:0] plen_shift;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic [2:0]             cnt_inc;
  logic [7:0]             key_byte;
  logic [6:0]             len_code;

  // The parse step runs when the result register can take its outcome.
  assign advance  = !res_valid || res.ready;
  assign rx.ready = !in_valid || advance;

  assign len_code   = in_byte[6:0] & wsd_pkg::HDR_LEN_MASK[6:0];
  assign plen_shift = {plen[LENGTH_BITS-9:0], in_byte};
  assign pos_inc    = pos + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign cnt_inc    = field_cnt + 3'd1;
  // Key bytes are applied most significant first: position 0 takes key[31:24].
  assign key_byte   = key[{~pos[1:0], 3'b000} +: 8];

  always_comb begin
    phase_next     = phase;
    field_cnt_next = field_cnt;
    fin_next       = fin;
    opcode_next    = opcode;
    masked_next    = masked;
    plen_next      = plen;
    key_next       = key;
    pos_next       = pos;
    emit           = 1'b0;
    emit_kind      = wsd_pkg::KIND_DATA;
    emit_data      = 8'd0;
    emit_masked    = 1'b0;
    emit_last      = 1'b1;
    len_done       = 1'b0;
    len_val        = plen;

    case (phase)
      wsd_pkg::PH_HDR1: begin
        masked_next = |(in_byte & wsd_pkg::HDR_FLAG_MASK);
        if (field_cnt != 3'd0) begin
          // Reserved bits were set in the first header byte.
          masked_next    = 1'b0;
          field_cnt_next = 3'd0;
          phase_next     = wsd_pkg::PH_HDR0;
          emit           = 1'b1;
          emit_kind      = wsd_pkg::KIND_ERROR;
        end else begin
          plen_next = '0;
          if (len_code == wsd_pkg::LEN_CODE_EXT16) begin
            phase_next = wsd_pkg::PH_EXT16;
          end else if (len_code == wsd_pkg::LEN_CODE_EXT64) begin
            phase_next = wsd_pkg::PH_EXT64;
          end else begin
            len_done = 1'b1;
            len_val  = {{(LENGTH_BITS-7){1'b0}}, len_code};
          end
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        plen_next      = plen_shift;
        field_cnt_next = cnt_inc;
        if ((phase == wsd_pkg::PH_EXT16 && cnt_inc == wsd_pkg::EXT16_BYTES) ||
            (phase == wsd_pkg::PH_EXT64 && cnt_inc == wsd_pkg::EXT64_BYTES)) begin
          len_done = 1'b1;
          len_val  = plen_shift;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_next       = {key[23:0], in_byte};
        field_cnt_next = cnt_inc;
        if (cnt_inc == wsd_pkg::KEY_BYTES) begin
          field_cnt_next = 3'd0;
          if (plen == '0) begin
            phase_next  = wsd_pkg::PH_HDR0;
            emit        = 1'b1;
            emit_kind   = wsd_pkg::KIND_EMPTY;
            emit_masked = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        emit        = 1'b1;
        emit_kind   = wsd_pkg::KIND_DATA;
        emit_data   = masked ? (in_byte ^ key_byte) : in_byte;
        emit_masked = masked;
        emit_last   = (pos_inc >= plen);
        if (pos_inc >= plen) begin
          phase_next = wsd_pkg::PH_HDR0;
          pos_next   = '0;
        end else begin
          pos_next = pos_inc;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        fin_next       = |(in_byte & wsd_pkg::HDR_FLAG_MASK);
        opcode_next    = in_byte[3:0] & wsd_pkg::HDR_OPCODE_MASK[3:0];
        field_cnt_next = (|(in_byte & wsd_pkg::HDR_RSV_MASK)) ? 3'd1 : 3'd0;
        phase_next     = wsd_pkg::PH_HDR1;
      end
    endcase

    // Length complete: go on to the key, to the payload, or close an empty frame.
    if (len_done) begin
      plen_next      = len_val;
      field_cnt_next = 3'd0;
      pos_next       = '0;
      if (masked_next) begin
        key_next   = '0;
        phase_next = wsd_pkg::PH_KEY;
      end else if (len_val == '0) begin
        phase_next = wsd_pkg::PH_HDR0;
        emit       = 1'b1;
        emit_kind  = wsd_pkg::KIND_EMPTY;
      end else begin
        phase_next = wsd_pkg::PH_DATA;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Frame state, updated once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsd_pkg::PH_HDR0;
      field_cnt <= 3'd0;
      fin       <= 1'b0;
      opcode    <= 4'd0;
      masked    <= 1'b0;
      plen      <= '0;
      key       <= '0;
      pos       <= '0;
    end else if (in_valid && advance) begin
      phase     <= phase_next;
      field_cnt <= field_cnt_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      masked    <= masked_next;
      plen      <= plen_next;
      key       <= key_next;
      pos       <= pos_next;
    end
  end

  // Result register. Header fields are taken from the current frame state,
  // which a result-producing byte never changes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && emit;
    end
    if (advance && in_valid && emit) begin
      res_kind   <= emit_kind;
      res_data   <= emit_data;
      res_fin    <= fin;
      res_opcode <= opcode;
      res_masked <= emit_masked;
      res_last   <= emit_last;
    end
  end

  assign res.valid         = res_valid;
  assign res.out_kind      = res_kind;
  assign res.data_byte     = res_data;
  assign res.frame_fin     = res_fin;
  assign res.frame_opcode  = res_opcode;
  assign res.was_masked    = res_masked;
  assign res.last_of_frame = res_last;

endmodule

`default_nettype wire
